[rtl/trr_pkg.sv]
// Shared types and constants for the TFTP read receiver.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package trr_pkg;

  // Protocol constants
  localparam logic [7:0]  OP_DATA        = 8'h03;
  localparam logic [7:0]  OP_ERROR       = 8'h05;
  localparam logic [15:0] HDR_LEN        = 16'd4;
  localparam logic [15:0] FULL_PACKET    = 16'd516;
  localparam logic [15:0] LAST_BLOCK     = 16'hFFFF;
  localparam logic [31:0] ACK_WAIT_RESET = 32'd1 << 11;

  // Divider geometry: elapsed ms over block count
  localparam int DVD_W = 32;
  localparam int DVS_W = 16;
  localparam int CNT_W = $clog2(DVD_W);

  // Transfer status as reported on the result
  typedef enum logic [2:0] {
    ST_RUNNING    = 3'd0,
    ST_DONE       = 3'd1,
    ST_SERVER_ERR = 3'd2,
    ST_TIMEOUT    = 3'd3,
    ST_TOO_LARGE  = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_START   = 1'b1
  } cfg_reg_t;

  // Request kinds
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_DIV,
    S_FIN
  } state_t;

  // Input word: packet header or timer tick
  typedef struct packed {
    logic        req_type;
    logic        from_server_addr;
    logic [15:0] src_port;
    logic [7:0]  first_byte;
    logic [7:0]  opcode_byte;
    logic [15:0] block_field;
    logic [15:0] packet_len;
    logic [31:0] now_ms;
  } item_t;

  // Result word
  typedef struct packed {
    logic        tx_ack;
    logic [15:0] ack_block;
    logic        send_request;
    logic        accept_payload;
    logic [15:0] payload_len;
    logic        dropped;
    logic [2:0]  status;
  } result_t;

  // Configuration write word
  typedef struct packed {
    cfg_reg_t    addr;
    logic [31:0] wdata;
  } cfg_word_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

[rtl/trr_ifs.sv]
// Valid/ready channel interfaces for the TFTP read receiver.
// Depends on trr_pkg for the word types.
`timescale 1ns / 1ps

interface trr_item_if;
  logic           valid;
  logic           ready;
  trr_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trr_result_if;
  logic             valid;
  logic             ready;
  trr_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trr_cfg_if;
  logic               valid;
  logic               ready;
  trr_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/trr_div.sv]
// Restoring divider, one quotient bit per cycle, for the per-block period.
// Depends on trr_pkg for the operand widths.
`timescale 1ns / 1ps

module trr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [trr_pkg::DVD_W-1:0]  dividend,
  input  logic [trr_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [trr_pkg::DVD_W-1:0]  quotient
);

  logic                      busy;
  logic [trr_pkg::CNT_W-1:0] cnt;
  logic [trr_pkg::DVS_W-1:0] rem;
  logic [trr_pkg::DVS_W:0]   rem_shift;
  logic [trr_pkg::DVS_W:0]   rem_diff;
  logic                      fits;

  // One trial subtraction
  always_comb begin
    rem_shift = {rem, quotient[trr_pkg::DVD_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = (rem_shift >= {1'b0, divisor});
  end

  // Control: count one step per quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == trr_pkg::CNT_W'(trr_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands: quotient bits shift in from the right as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[trr_pkg::DVD_W-2:0], fits};
      rem      <= fits ? rem_diff[trr_pkg::DVS_W-1:0] : rem_shift[trr_pkg::DVS_W-1:0];
    end
  end

endmodule

[rtl/trr_dp.sv]
// Datapath: configuration, transfer state, packet/tick decisions, result register.
// Depends on trr_pkg and trr_div.
`timescale 1ns / 1ps

module trr_dp (
  input  logic               clk,
  input  logic               rst,
  input  trr_pkg::ctrl_cmd_t cmd,
  output trr_pkg::dp_stat_t  stat,
  input  trr_pkg::item_t     item_in,
  input  logic               cfg_we,
  input  trr_pkg::cfg_word_t cfg_word,
  output trr_pkg::result_t   result_out
);

  // Configuration and transfer state
  logic [31:0]      client_timeout_ms;
  logic [31:0]      session_start_ms;
  logic [15:0]      block_count;
  logic [31:0]      ack_wait_ms;
  logic             port_locked;
  logic [15:0]      server_port;
  trr_pkg::status_t final_status;

  logic [15:0]      block_count_next;
  logic [31:0]      ack_wait_ms_next;
  logic             port_locked_next;
  logic [15:0]      server_port_next;
  trr_pkg::status_t final_status_next;

  trr_pkg::item_t   item_q;
  trr_pkg::result_t res, res_next;

  logic [31:0] elapsed;
  logic [31:0] period;
  logic        div_done;
  logic        bad;
  logic        is_err;
  logic        is_data;
  logic        take;
  logic        do_take;
  logic [15:0] bc_inc;
  logic [32:0] wait_sum;
  logic        to_on;

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) item_q <= item_in;
  end

  assign elapsed = item_q.now_ms - session_start_ms;

  trr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (elapsed),
    .divisor  (block_count),
    .done     (div_done),
    .quotient (period)
  );

  always_comb begin
    stat.need_div = (item_q.req_type == trr_pkg::REQ_TICK) &&
                    (final_status == trr_pkg::ST_RUNNING) && (block_count != 16'd0);
    stat.div_done = div_done;
  end

  // Header checks
  always_comb begin
    bad     = (item_q.packet_len < trr_pkg::HDR_LEN) || (item_q.first_byte != 8'd0);
    bc_inc  = block_count + 16'd1;
    is_err  = !bad && (item_q.opcode_byte == trr_pkg::OP_ERROR);
    is_data = !bad && (item_q.opcode_byte == trr_pkg::OP_DATA) &&
              ({1'b0, item_q.block_field} == ({1'b0, block_count} + 17'd1));
    take    = is_err || is_data;
    to_on   = (client_timeout_ms != 32'd0);
    wait_sum = {1'b0, period} + {2'b0, period[31:1]};
  end

  // Step decision and next state
  always_comb begin
    res_next          = '0;
    block_count_next  = block_count;
    ack_wait_ms_next  = ack_wait_ms;
    port_locked_next  = port_locked;
    server_port_next  = server_port;
    final_status_next = final_status;
    do_take           = 1'b0;

    if (item_q.req_type == trr_pkg::REQ_TICK) begin
      if (final_status == trr_pkg::ST_RUNNING) begin
        if (block_count == 16'd0) begin
          if (to_on && (client_timeout_ms < elapsed)) begin
            final_status_next = trr_pkg::ST_TIMEOUT;
            ack_wait_ms_next  = '0;
          end else begin
            res_next.send_request = 1'b1;
          end
        end else if (to_on && (client_timeout_ms < period)) begin
          final_status_next = trr_pkg::ST_TIMEOUT;
          ack_wait_ms_next  = '0;
        end else begin
          if (ack_wait_ms < period) begin
            res_next.tx_ack    = 1'b1;
            res_next.ack_block = block_count;
          end
          ack_wait_ms_next = wait_sum[32] ? '1 : wait_sum[31:0];
        end
      end
    end else if (final_status != trr_pkg::ST_RUNNING) begin
      res_next.dropped = 1'b1;
    end else if (!port_locked) begin
      if (!item_q.from_server_addr) begin
        res_next.dropped = 1'b1;
      end else if (take) begin
        do_take          = 1'b1;
        port_locked_next = 1'b1;
        server_port_next = item_q.src_port;
      end else begin
        res_next.dropped      = 1'b1;
        res_next.send_request = 1'b1;
      end
    end else begin
      if (!item_q.from_server_addr || (item_q.src_port != server_port)) begin
        res_next.dropped = 1'b1;
      end else if (take) begin
        do_take = 1'b1;
      end else begin
        res_next.dropped   = 1'b1;
        res_next.tx_ack    = 1'b1;
        res_next.ack_block = block_count;
      end
    end

    // Consumed packet: error or next data block
    if (do_take) begin
      if (is_err) begin
        final_status_next = trr_pkg::ST_SERVER_ERR;
        ack_wait_ms_next  = '0;
      end else begin
        block_count_next   = bc_inc;
        res_next.tx_ack    = 1'b1;
        res_next.ack_block = bc_inc;
        if (item_q.packet_len < trr_pkg::FULL_PACKET) begin
          res_next.accept_payload = 1'b1;
          res_next.payload_len    = item_q.packet_len - trr_pkg::HDR_LEN;
          final_status_next       = trr_pkg::ST_DONE;
          ack_wait_ms_next        = '0;
        end else if (bc_inc == trr_pkg::LAST_BLOCK) begin
          final_status_next = trr_pkg::ST_TOO_LARGE;
          ack_wait_ms_next  = '0;
        end else begin
          res_next.accept_payload = 1'b1;
          res_next.payload_len    = item_q.packet_len - trr_pkg::HDR_LEN;
        end
      end
    end

    res_next.status = final_status_next;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      client_timeout_ms <= '0;
      session_start_ms  <= '0;
      block_count       <= '0;
      ack_wait_ms       <= trr_pkg::ACK_WAIT_RESET;
      port_locked       <= 1'b0;
      server_port       <= '0;
      final_status      <= trr_pkg::ST_RUNNING;
    end else begin
      if (cfg_we) begin
        unique case (cfg_word.addr)
          trr_pkg::REG_TIMEOUT: client_timeout_ms <= cfg_word.wdata;
          trr_pkg::REG_START:   session_start_ms  <= cfg_word.wdata;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        block_count  <= block_count_next;
        ack_wait_ms  <= ack_wait_ms_next;
        port_locked  <= port_locked_next;
        server_port  <= server_port_next;
        final_status <= final_status_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) res <= res_next;
  end

  assign result_out = res;

endmodule

[rtl/trr_ctrl.sv]
// Controller: sequences accept, optional divide and result hand-off.
// Depends on trr_pkg for the state and command types.
`timescale 1ns / 1ps

module trr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  trr_pkg::dp_stat_t  stat,
  output trr_pkg::ctrl_cmd_t cmd
);

  trr_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      trr_pkg::S_IDLE: if (in_valid) state_next = trr_pkg::S_PROC;
      trr_pkg::S_PROC: begin
        if (stat.need_div)  state_next = trr_pkg::S_DIV;
        else if (out_free)  state_next = trr_pkg::S_IDLE;
      end
      trr_pkg::S_DIV:  if (stat.div_done) state_next = trr_pkg::S_FIN;
      trr_pkg::S_FIN:  if (out_free) state_next = trr_pkg::S_IDLE;
      default:         state_next = trr_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = (state == trr_pkg::S_IDLE);
    cmd.latch     = in_valid && (state == trr_pkg::S_IDLE);
    cmd.div_start = (state == trr_pkg::S_PROC) && stat.need_div;
    cmd.commit    = out_free && (((state == trr_pkg::S_PROC) && !stat.need_div) ||
                                 (state == trr_pkg::S_FIN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[rtl/tftp_read_receiver_core.sv]
// Top level of the TFTP read receiver: controller, datapath and channels.
// Depends on trr_pkg, trr_ifs, trr_ctrl and trr_dp.
`timescale 1ns / 1ps

// Follows one TFTP read transfer, taking one packet header or timer tick per
// word on item and giving one result word on result. A packet header is latched
// on acceptance and its result registered in S_PROC once result is free; a tick
// after the first data block first passes the one-bit-per-cycle 32-by-16 divide
// of elapsed time by block count. A new word is accepted while the previous
// result waits on result. Configuration writes (0: timeout ms, 1: session start
// ms) are always taken and must only be issued while the block is idle.
module tftp_read_receiver_core (
  input logic         clk,
  input logic         rst,
  trr_item_if.sink    item,
  trr_result_if.source result,
  trr_cfg_if.sink     cfg
);

  trr_pkg::ctrl_cmd_t cmd;
  trr_pkg::dp_stat_t  stat;

  assign cfg.ready = 1'b1;

  trr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  trr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .item_in    (item.data),
    .cfg_we     (cfg.valid),
    .cfg_word   (cfg.data),
    .result_out (result.data)
  );

  // A result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");

  // No new word is taken while the divider finishes
  a_busy_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> !item.ready)
    else $error("word accepted during divide");

  // After a word is accepted the input is closed in the cycle after
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("second word accepted while one is in work");

  // Each commit raises result valid
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result.valid)
    else $error("commit did not present a result");

endmodule

[tb/sv/tb.sv]
// Self-checking bench for tftp_read_receiver_core: directed rows, then random words.
// Depends on trr_pkg, the trr_ifs channel interfaces and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;
  import trr_pkg::*;

  localparam longint WATCHDOG_NS = 5_000_000;

  // Transfer state as the bench tracks it
  typedef struct packed {
    logic [15:0] blocks;
    logic [31:0] ack_wait;
    logic        locked;
    logic [15:0] port;
    status_t     status;
  } xfer_t;

  typedef struct packed {
    xfer_t   s;
    result_t r;
  } step_t;

  // One row of the directed table; pin marks a hand-written response
  typedef struct packed {
    item_t   w;
    logic    pin;
    result_t r;
  } row_t;

  localparam result_t ANY = '0;

  logic clk;
  logic rst;

  trr_item_if   item_ch ();
  trr_result_if res_ch ();
  trr_cfg_if    cfg_ch ();

  tftp_read_receiver_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  xfer_t       xfer;
  logic [31:0] tmo_ms;
  logic [31:0] start_ms;
  result_t     resp_due_q[$];
  row_t        plan[$];
  logic        pinned_valid;
  result_t     pinned_res;
  logic        gaps_on;
  logic        stalls_on;
  int unsigned hold_left;
  int unsigned faults;

  always #1 clk = ~clk;

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("tftp_read_receiver_core test failed");
    $finish;
  end

  // Response for one word; returns the updated transfer state too
  function automatic step_t rx_advance(input xfer_t s, input item_t w,
                                       input logic [31:0] tmo, input logic [31:0] t0);
    result_t     r;
    logic        taken;
    logic [31:0] elapsed;
    logic [31:0] period;
    logic [32:0] grown;
    r = '0;
    taken = 1'b0;
    if (w.req_type == REQ_TICK) begin
      if (s.status == ST_RUNNING) begin
        elapsed = w.now_ms - t0;
        if (s.blocks == 16'd0) begin
          if (tmo != 0 && tmo < elapsed) begin
            s.status = ST_TIMEOUT;
            s.ack_wait = '0;
          end else begin
            r.send_request = 1'b1;
          end
        end else begin
          period = elapsed / {16'd0, s.blocks};
          if (tmo != 0 && tmo < period) begin
            s.status = ST_TIMEOUT;
            s.ack_wait = '0;
          end else begin
            if (s.ack_wait < period) begin
              r.tx_ack = 1'b1;
              r.ack_block = s.blocks;
            end
            // one and a half periods, saturating
            grown = {1'b0, period} + {2'b0, period[31:1]};
            s.ack_wait = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
          end
        end
      end
    end else if (s.status != ST_RUNNING) begin
      r.dropped = 1'b1;
    end else if (!w.from_server_addr || (s.locked && w.src_port != s.port)) begin
      r.dropped = 1'b1;
    end else begin
      // header checks, then error or next data block
      if (w.packet_len >= HDR_LEN && w.first_byte == 8'd0) begin
        if (w.opcode_byte == OP_ERROR) begin
          taken = 1'b1;
          s.status = ST_SERVER_ERR;
          s.ack_wait = '0;
        end else if (w.opcode_byte == OP_DATA &&
                     {1'b0, w.block_field} == {1'b0, s.blocks} + 17'd1) begin
          taken = 1'b1;
          s.blocks = s.blocks + 16'd1;
          r.tx_ack = 1'b1;
          r.ack_block = s.blocks;
          if (w.packet_len < FULL_PACKET) begin
            r.accept_payload = 1'b1;
            r.payload_len = w.packet_len - HDR_LEN;
            s.status = ST_DONE;
            s.ack_wait = '0;
          end else if (s.blocks == LAST_BLOCK) begin
            s.status = ST_TOO_LARGE;
            s.ack_wait = '0;
          end else begin
            r.accept_payload = 1'b1;
            r.payload_len = w.packet_len - HDR_LEN;
          end
        end
      end
      if (taken) begin
        if (!s.locked) begin
          s.locked = 1'b1;
          s.port = w.src_port;
        end
      end else if (!s.locked) begin
        r.dropped = 1'b1;
        r.send_request = 1'b1;
      end else begin
        r.dropped = 1'b1;
        r.tx_ack = 1'b1;
        r.ack_block = s.blocks;
      end
    end
    r.status = s.status;
    return {s, r};
  endfunction

  function automatic item_t pkt(input logic src, input logic [15:0] port,
                                input logic [7:0] first, input logic [7:0] op,
                                input logic [15:0] blk, input logic [15:0] len);
    item_t w;
    w = '0;
    w.req_type = REQ_PACKET;
    w.from_server_addr = src;
    w.src_port = port;
    w.first_byte = first;
    w.opcode_byte = op;
    w.block_field = blk;
    w.packet_len = len;
    w.now_ms = $urandom;
    return w;
  endfunction

  function automatic item_t tk(input logic [31:0] now);
    item_t w;
    w = '0;
    w.req_type = REQ_TICK;
    w.now_ms = now;
    return w;
  endfunction

  function automatic result_t res(input logic ack, input logic [15:0] ablk, input logic req,
                                  input logic acc, input logic [15:0] plen, input logic drop,
                                  input status_t st);
    result_t r;
    r.tx_ack = ack;
    r.ack_block = ablk;
    r.send_request = req;
    r.accept_payload = acc;
    r.payload_len = plen;
    r.dropped = drop;
    r.status = st;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pause_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Tick time near a plausible per-block period, sometimes anywhere
  function automatic logic [31:0] pick_time();
    logic [31:0] p;
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    p = $urandom_range(0, 6000);
    return start_ms + p * xfer.blocks + $urandom_range(0, xfer.blocks);
  endfunction

  // Mostly the next data block, some ticks, the rest broken or foreign packets
  function automatic item_t pick_item();
    item_t        w;
    int unsigned  k;
    logic [127:0] rnd;
    w = pkt(1'b1, xfer.port, 8'd0, OP_DATA, xfer.blocks + 16'd1,
            ($urandom_range(0, 3) == 0) ? FULL_PACKET : 16'($urandom_range(516, 65535)));
    k = $urandom_range(0, 99);
    if (k >= 55 && k < 72) begin
      w = tk(pick_time());
    end else if (k >= 72) begin
      case ($urandom_range(0, 7))
        0: begin
          rnd = {$urandom, $urandom, $urandom, $urandom};
          w = rnd[$bits(item_t)-1:0];
        end
        1: w.from_server_addr = 1'b0;
        2: w.src_port = 16'($urandom);
        3: w.first_byte = 8'($urandom_range(1, 255));
        4: w.opcode_byte = 8'($urandom);
        5: w.block_field = 16'($urandom);
        6: w.packet_len = 16'($urandom_range(0, 3));
        default: begin
          w.packet_len = 16'($urandom_range(4, 515));
          w.block_field = xfer.blocks;
        end
      endcase
    end
    return w;
  endfunction

  // Random word that keeps the transfer running
  function automatic item_t safe_item();
    item_t w;
    step_t nx;
    for (int i = 0; i < 8; i++) begin
      w = pick_item();
      nx = rx_advance(xfer, w, tmo_ms, start_ms);
      if (nx.s.status == ST_RUNNING)
        return w;
    end
    return tk(start_ms);
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      faults++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input item_t w, input logic pin, input result_t pres);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_valid = pin;
    pinned_res = pres;
    item_ch.data <= w;
    item_ch.valid <= 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every response is back
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (resp_due_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write timeout then session start, valid held across both words
  task automatic set_timing(input logic [31:0] tmo, input logic [31:0] t0);
    cfg_word_t cw;
    cw.addr = REG_TIMEOUT;
    cw.wdata = tmo;
    cfg_ch.data <= cw;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cw.addr = REG_START;
    cw.wdata = t0;
    cfg_ch.data <= cw;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result-side back-pressure
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0)
        hold_left = pause_len();
    end
  end

  // Check responses, predict on accepted words, mirror register writes
  always @(posedge clk) begin : watch
    step_t   nx;
    result_t want;
    result_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (resp_due_q.size() == 0) begin
          $display("%0t: response word with none expected: %0h", $time, got);
          faults++;
        end else begin
          want = resp_due_q.pop_front();
          cmp_field("tx_ack", 32'(want.tx_ack), 32'(got.tx_ack));
          cmp_field("ack_block", 32'(want.ack_block), 32'(got.ack_block));
          cmp_field("send_request", 32'(want.send_request), 32'(got.send_request));
          cmp_field("accept_payload", 32'(want.accept_payload), 32'(got.accept_payload));
          cmp_field("payload_len", 32'(want.payload_len), 32'(got.payload_len));
          cmp_field("dropped", 32'(want.dropped), 32'(got.dropped));
          cmp_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        nx = rx_advance(xfer, item_ch.data, tmo_ms, start_ms);
        xfer = nx.s;
        resp_due_q.push_back(pinned_valid ? pinned_res : nx.r);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.addr)
          REG_TIMEOUT: tmo_ms = cfg_ch.data.wdata;
          REG_START:   start_ms = cfg_ch.data.wdata;
          default: ;
        endcase
      end
    end
  end

  initial begin : stim
    int unsigned end_kind;
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    hold_left = 0;
    faults = 0;
    pinned_valid = 1'b0;
    pinned_res = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    tmo_ms = '0;
    start_ms = '0;
    xfer = {16'd0, ACK_WAIT_RESET, 1'b0, 16'd0, ST_RUNNING};

    // Directed rows: before the port locks, locking, after lock, ack-wait ticks
    plan.push_back({tk(32'h0), 1'b1, res(0, 0, 1, 0, 0, 0, ST_RUNNING)});
    plan.push_back({tk(32'hFFFF_FFFF), 1'b1, res(0, 0, 1, 0, 0, 0, ST_RUNNING)});
    plan.push_back({pkt(0, 16'hFFFF, 0, OP_DATA, 1, FULL_PACKET), 1'b1,
                    res(0, 0, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'h0, 0, OP_DATA, 1, 16'd3), 1'b1,
                    res(0, 0, 1, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'h0, 8'hFF, OP_DATA, 1, FULL_PACKET), 1'b1,
                    res(0, 0, 1, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'h0, 0, 8'h04, 1, FULL_PACKET), 1'b1,
                    res(0, 0, 1, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'h0, 0, OP_DATA, 2, FULL_PACKET), 1'b1,
                    res(0, 0, 1, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 1, FULL_PACKET), 1'b1,
                    res(1, 1, 0, 1, 512, 0, ST_RUNNING)});
    plan.push_back({tk(32'hFFFF_FFFF), 1'b1, res(1, 1, 0, 0, 0, 0, ST_RUNNING)});
    plan.push_back({tk(32'hFFFF_FFFF), 1'b1, res(0, 0, 0, 0, 0, 0, ST_RUNNING)});
    plan.push_back({pkt(1, 16'h0, 0, OP_DATA, 2, FULL_PACKET), 1'b1,
                    res(0, 0, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(0, 16'hFFFF, 0, OP_DATA, 2, FULL_PACKET), 1'b1,
                    res(0, 0, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 2, 16'd0), 1'b1,
                    res(1, 1, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 8'h80, OP_DATA, 2, FULL_PACKET), 1'b1,
                    res(1, 1, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 1, FULL_PACKET), 1'b1,
                    res(1, 1, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, 8'hFF, 2, FULL_PACKET), 1'b1,
                    res(1, 1, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_ERROR, 2, 16'd3), 1'b1,
                    res(1, 1, 0, 0, 0, 1, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 2, 16'hFFFF), 1'b1,
                    res(1, 2, 0, 1, 16'd65531, 0, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 3, FULL_PACKET), 1'b1,
                    res(1, 3, 0, 1, 512, 0, ST_RUNNING)});
    plan.push_back({tk(32'h0), 1'b1, res(0, 0, 0, 0, 0, 0, ST_RUNNING)});
    plan.push_back({tk(32'hFFFF_FFFF), 1'b1, res(1, 3, 0, 0, 0, 0, ST_RUNNING)});
    plan.push_back({tk(32'd6000), 1'b0, ANY});
    plan.push_back({tk(32'd12000), 1'b0, ANY});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 4, 16'd1000), 1'b1,
                    res(1, 4, 0, 1, 996, 0, ST_RUNNING)});
    plan.push_back({pkt(1, 16'hFFFF, 0, OP_DATA, 5, FULL_PACKET), 1'b0, ANY});

    // Reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i])
      send_word(plan[i].w, plan[i].pin, plan[i].r);

    // Random words under several timing settings; one stretch without idling
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_timing(32'hFFFF_FFFF, 32'h0);
        1: set_timing(32'h0, 32'hFFFF_FFFF);
        2: set_timing($urandom_range(2000, 200000), $urandom);
        default: set_timing($urandom_range(1, 50), $urandom);
      endcase
      gaps_on = (ph != 1);
      stalls_on = (ph != 1);
      repeat (150) send_word(safe_item(), 1'b0, ANY);
    end

    // Close the transfer one way, picked at random
    drain();
    end_kind = $urandom_range(0, 2);
    case (end_kind)
      0: send_word(pkt(1, xfer.port, 0, OP_DATA, xfer.blocks + 16'd1,
                       16'($urandom_range(4, 515))), 1'b0, ANY);
      1: send_word(pkt(1, xfer.port, 0, OP_ERROR, 16'($urandom),
                       16'($urandom_range(4, 65535))), 1'b0, ANY);
      default: begin
        set_timing(32'd1, 32'h0);
        send_word(tk(32'hFFFF_FFFF), 1'b0, ANY);
      end
    endcase

    // After the end everything is dropped or ignored
    drain();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (12) send_word(pick_item(), 1'b0, ANY);

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (resp_due_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (faults == 0)
      $display("tftp_read_receiver_core test passed");
    else
      $display("tftp_read_receiver_core test failed");
    $finish;
  end

endmodule
